// ----- rtl/core/ps2mpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types, register indexes, reset values and the per-axis move/clamp
// function for the PS/2 mouse position tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

    localparam int AXIS_W   = 15;
    localparam int SCALE_W  = 5;
    localparam int NIBBLE_W = 4;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 15;
    // Signed working width for pos + delta * scale
    localparam int SUM_W    = AXIS_W + 2;

    typedef logic [AXIS_W-1:0]   axis_t;
    typedef logic [SCALE_W-1:0]  scale_t;
    typedef logic [NIBBLE_W-1:0] nibble_t;
    typedef logic [BYTE_W-1:0]   byte_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_X_LIMIT = 2'd0,
        CFG_Y_LIMIT = 2'd1,
        CFG_X_SCALE = 2'd2,
        CFG_Y_SCALE = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam axis_t  X_LIMIT_RST = 15'd639;
    localparam axis_t  Y_LIMIT_RST = 15'd479;
    localparam scale_t X_SCALE_RST = 5'd1;
    localparam scale_t Y_SCALE_RST = 5'd1;

    // Flag byte bit positions
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MIDDLE = 2;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;

    // One axis: 9-bit signed delta times scale, added to pos, clamped to [0, limit]
    function automatic axis_t move_axis(
        input axis_t  pos,
        input byte_t  raw,
        input logic   neg,
        input scale_t scale,
        input axis_t  limit
    );
        logic signed [SUM_W-1:0] delta;
        logic signed [SUM_W-1:0] scale_s;
        logic signed [SUM_W-1:0] prod;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] limit_s;
        axis_t                   res;
        delta   = SUM_W'($signed({neg, raw}));
        scale_s = $signed({{(SUM_W-SCALE_W){1'b0}}, scale});
        prod    = delta * scale_s;
        sum     = $signed({2'b00, pos}) + prod;
        limit_s = $signed({2'b00, limit});
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (sum > limit_s) begin
            res = limit;
        end else begin
            res = sum[AXIS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/ps2_mouse_position_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_position_tracker
// Decodes four-byte PS/2 mouse packets into a clamped cursor position,
// latched buttons and the last nonzero scroll nibble.
// ----------------------------------------------------------------------------
// Each input beat passes the input register, then the cursor/result register.
// Throughput: one packet per cycle unless m_tready stalls; the cursor register
// feeds back into the next packet's combinational multiply/add/clamp.
// Reset (aresetn low, synchronous): cursor, buttons and scroll cleared,
// limits 639/479, scales 1, both stages empty.
module ps2_mouse_position_tracker (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wdata,

    // Packet input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // flag_byte[7:0], x_byte[15:8], y_byte[23:16],
                                   // scroll_byte[31:24]
    input  logic        s_tuser,   // complete

    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // pos_x[14:0], pos_y[29:15], button_left[30],
                                   // button_middle[31], button_right[32],
                                   // scroll_value[36:33], zero fill[39:37]
);

    // Configuration registers
    ps2mpt_pkg::axis_t  x_limit_reg;
    ps2mpt_pkg::axis_t  y_limit_reg;
    ps2mpt_pkg::scale_t x_scale_reg;
    ps2mpt_pkg::scale_t y_scale_reg;

    // Input stage
    logic                in_valid_reg;
    logic                in_complete_reg;
    ps2mpt_pkg::byte_t   in_flag_reg;
    ps2mpt_pkg::byte_t   in_x_reg;
    ps2mpt_pkg::byte_t   in_y_reg;
    ps2mpt_pkg::nibble_t in_scroll_reg;

    // Tracker state, which doubles as the result register
    logic                out_valid_reg;
    ps2mpt_pkg::axis_t   cursor_x_reg;
    ps2mpt_pkg::axis_t   cursor_y_reg;
    logic [2:0]          buttons_reg;
    ps2mpt_pkg::nibble_t scroll_reg;

    ps2mpt_pkg::axis_t   cursor_x_next;
    ps2mpt_pkg::axis_t   cursor_y_next;

    logic advance;
    logic load_out;

    // Result stage can take a new beat when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign load_out = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= ps2mpt_pkg::X_LIMIT_RST;
            y_limit_reg <= ps2mpt_pkg::Y_LIMIT_RST;
            x_scale_reg <= ps2mpt_pkg::X_SCALE_RST;
            y_scale_reg <= ps2mpt_pkg::Y_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (ps2mpt_pkg::cfg_index_t'(cfg_index))
                ps2mpt_pkg::CFG_X_LIMIT: x_limit_reg <= cfg_wdata;
                ps2mpt_pkg::CFG_Y_LIMIT: y_limit_reg <= cfg_wdata;
                ps2mpt_pkg::CFG_X_SCALE: x_scale_reg <= cfg_wdata[ps2mpt_pkg::SCALE_W-1:0];
                ps2mpt_pkg::CFG_Y_SCALE: y_scale_reg <= cfg_wdata[ps2mpt_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register: payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_complete_reg <= s_tuser;
            in_flag_reg     <= s_tdata[7:0];
            in_x_reg        <= s_tdata[15:8];
            in_y_reg        <= s_tdata[23:16];
            in_scroll_reg   <= s_tdata[27:24];
        end
    end

    // Per-axis move and clamp
    always_comb begin
        cursor_x_next = ps2mpt_pkg::move_axis(cursor_x_reg, in_x_reg,
                                              in_flag_reg[ps2mpt_pkg::FLAG_XSIGN],
                                              x_scale_reg, x_limit_reg);
        cursor_y_next = ps2mpt_pkg::move_axis(cursor_y_reg, in_y_reg,
                                              in_flag_reg[ps2mpt_pkg::FLAG_YSIGN],
                                              y_scale_reg, y_limit_reg);
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Tracker state; only a complete packet changes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            buttons_reg  <= '0;
            scroll_reg   <= '0;
        end else if (load_out && in_complete_reg) begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            buttons_reg  <= in_flag_reg[2:0];
            if (in_scroll_reg != '0) begin
                scroll_reg <= in_scroll_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       scroll_reg,
                       buttons_reg[ps2mpt_pkg::FLAG_RIGHT],
                       buttons_reg[ps2mpt_pkg::FLAG_MIDDLE],
                       buttons_reg[ps2mpt_pkg::FLAG_LEFT],
                       cursor_y_reg,
                       cursor_x_reg};

endmodule

// ----- dv/ps2_mouse_position_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_position_tracker_tb
// Self-checking bench for the PS/2 mouse position tracker. Packets go in over
// the slave stream and each one is run through a local cursor tracker that
// keeps its own position, buttons, scroll and register copies. Every result
// beat is checked against the oldest predicted report. Directed packets cover
// field extremes, sign handling, clamping, ignored flag bits, incomplete
// packets, zero scroll nibbles, unusual scales and a limit lowered under the
// cursor. Random traffic follows under several register settings and
// backpressure profiles.
// ----------------------------------------------------------------------------
module ps2_mouse_position_tracker_tb;

    // One packet as it goes onto the slave stream
    typedef struct packed {
        logic              complete;
        ps2mpt_pkg::byte_t flags;
        ps2mpt_pkg::byte_t dx;
        ps2mpt_pkg::byte_t dy;
        ps2mpt_pkg::byte_t wheel;
    } mouse_packet_t;

    // One report as it comes off the master stream
    typedef struct packed {
        ps2mpt_pkg::axis_t   pos_x;
        ps2mpt_pkg::axis_t   pos_y;
        logic                left;
        logic                middle;
        logic                right;
        ps2mpt_pkg::nibble_t scroll;
    } cursor_report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = ps2mpt_pkg::CFG_X_LIMIT;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;  // flag_byte, x_byte, y_byte, scroll_byte
    logic        s_tuser   = 1'b0;  // complete
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;  // pos_x, pos_y, button_left, button_middle,
                           // button_right, scroll_value, zero fill

    ps2_mouse_position_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Tracker copy of registers and state
    ps2mpt_pkg::axis_t   lim_x = ps2mpt_pkg::X_LIMIT_RST;
    ps2mpt_pkg::axis_t   lim_y = ps2mpt_pkg::Y_LIMIT_RST;
    ps2mpt_pkg::scale_t  gain_x = ps2mpt_pkg::X_SCALE_RST;
    ps2mpt_pkg::scale_t  gain_y = ps2mpt_pkg::Y_SCALE_RST;
    ps2mpt_pkg::axis_t   cur_x = '0;
    ps2mpt_pkg::axis_t   cur_y = '0;
    logic [2:0]          held_buttons = '0;  // left, right, middle from bit 0 up
    ps2mpt_pkg::nibble_t held_scroll = '0;

    cursor_report_t pending_reports[$];

    int fault_count   = 0;
    int shown_faults  = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("ps2_mouse_position_tracker_tb: errors");
        $finish;
    end

    // Result sink with random stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // One axis: 9-bit signed delta times gain, clamped to [0, lim]
    function automatic ps2mpt_pkg::axis_t step_axis(ps2mpt_pkg::axis_t pos,
                                                    ps2mpt_pkg::byte_t mag, logic neg,
                                                    ps2mpt_pkg::scale_t gain,
                                                    ps2mpt_pkg::axis_t lim);
        int delta;
        int nxt;
        delta = int'(mag);
        if (neg) begin
            delta -= 256;
        end
        nxt = int'(pos) + delta * int'(gain);
        if (nxt > int'(lim)) begin
            nxt = int'(lim);
        end
        if (nxt < 0) begin
            nxt = 0;
        end
        return ps2mpt_pkg::axis_t'(nxt);
    endfunction

    // Advance the tracker by one packet and return the report it yields
    function automatic cursor_report_t track_packet(mouse_packet_t pkt);
        cursor_report_t rpt;
        if (pkt.complete) begin
            cur_x = step_axis(cur_x, pkt.dx, pkt.flags[ps2mpt_pkg::FLAG_XSIGN],
                              gain_x, lim_x);
            cur_y = step_axis(cur_y, pkt.dy, pkt.flags[ps2mpt_pkg::FLAG_YSIGN],
                              gain_y, lim_y);
            held_buttons = pkt.flags[2:0];
            if (pkt.wheel[3:0] != 4'd0) begin
                held_scroll = pkt.wheel[3:0];
            end
        end
        rpt.pos_x  = cur_x;
        rpt.pos_y  = cur_y;
        rpt.left   = held_buttons[ps2mpt_pkg::FLAG_LEFT];
        rpt.middle = held_buttons[ps2mpt_pkg::FLAG_MIDDLE];
        rpt.right  = held_buttons[ps2mpt_pkg::FLAG_RIGHT];
        rpt.scroll = held_scroll;
        return rpt;
    endfunction

    // Result checker
    always @(posedge aclk) begin
        cursor_report_t got;
        cursor_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x  = m_tdata[14:0];
            got.pos_y  = m_tdata[29:15];
            got.left   = m_tdata[30];
            got.middle = m_tdata[31];
            got.right  = m_tdata[32];
            got.scroll = m_tdata[36:33];
            if (pending_reports.size() == 0) begin
                fault_count++;
                if (shown_faults < 10) begin
                    shown_faults++;
                    $display("%0t: unexpected result beat x=%0d y=%0d", $realtime,
                             got.pos_x, got.pos_y);
                end
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (shown_faults < 10) begin
                        shown_faults++;
                        $display("%0t: mismatch exp x=%0d y=%0d l=%b m=%b r=%b s=%0d",
                                 $realtime, want.pos_x, want.pos_y, want.left,
                                 want.middle, want.right, want.scroll);
                        $display("%0t:          got x=%0d y=%0d l=%b m=%b r=%b s=%0d",
                                 $realtime, got.pos_x, got.pos_y, got.left,
                                 got.middle, got.right, got.scroll);
                    end
                end
            end
        end
    end

    // Send one packet beat; valid stays high after acceptance
    task automatic send_packet(input mouse_packet_t pkt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pkt.wheel, pkt.dy, pkt.dx, pkt.flags};
        s_tuser  <= pkt.complete;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_reports.push_back(track_packet(pkt));
    endtask

    task automatic send_fields(input logic complete, input ps2mpt_pkg::byte_t flags,
                               input ps2mpt_pkg::byte_t dx, input ps2mpt_pkg::byte_t dy,
                               input ps2mpt_pkg::byte_t wheel);
        mouse_packet_t pkt;
        pkt = '{complete, flags, dx, dy, wheel};
        send_packet(pkt);
    endtask

    // Stop sending and wait until every report is back
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Register write; enable is left high for the caller to drop
    task automatic write_reg(input ps2mpt_pkg::cfg_index_t idx, input logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            ps2mpt_pkg::CFG_X_LIMIT: lim_x = val;
            ps2mpt_pkg::CFG_Y_LIMIT: lim_y = val;
            ps2mpt_pkg::CFG_X_SCALE: gain_x = val[ps2mpt_pkg::SCALE_W-1:0];
            ps2mpt_pkg::CFG_Y_SCALE: gain_y = val[ps2mpt_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [14:0] xl, input logic [14:0] yl,
                                  input logic [14:0] xs, input logic [14:0] ys);
        write_reg(ps2mpt_pkg::CFG_X_LIMIT, xl);
        write_reg(ps2mpt_pkg::CFG_Y_LIMIT, yl);
        write_reg(ps2mpt_pkg::CFG_X_SCALE, xs);
        write_reg(ps2mpt_pkg::CFG_Y_SCALE, ys);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [14:0] pick_limit();
        case ($urandom_range(3))
            0: return 15'd0;
            1: return 15'h7FFF;
            2: return 15'($urandom_range(1, 1023));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [14:0] pick_scale();
        if ($urandom_range(1)) begin
            return 15'($urandom_range(1, 4));
        end
        return 15'($urandom_range(0, 32767));
    endfunction

    // Reset register values: signs, buttons, clamps, ignored bits, scroll
    task automatic test_basic_packets();
        send_fields(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // incomplete from reset
        send_fields(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(1'b1, 8'h07, 8'hFF, 8'hFF, 8'h0F);
        send_fields(1'b1, 8'h01, 8'hFF, 8'hFF, 8'hF0);  // zero nibble keeps scroll
        send_fields(1'b1, 8'h02, 8'hFF, 8'hFF, 8'h01);  // clamps at reset limits
        send_fields(1'b1, 8'h04, 8'h00, 8'h00, 8'h00);
        send_fields(1'b1, 8'h30, 8'h00, 8'h00, 8'h00);  // most negative deltas
        send_fields(1'b1, 8'h30, 8'h00, 8'h00, 8'h00);
        send_fields(1'b1, 8'h30, 8'h01, 8'hFF, 8'h00);  // floor at zero
        send_fields(1'b1, 8'hC8, 8'h80, 8'h80, 8'hA5);  // unused flag bits set
        send_fields(1'b0, 8'h37, 8'h12, 8'h34, 8'h0C);  // incomplete repeats state
        send_fields(1'b1, 8'h10, 8'hFF, 8'h7F, 8'h00);
        drain_reports();
    endtask

    // Register extremes, zero and oversized scales, limit dropped under cursor
    task automatic test_register_extremes();
        apply_settings(15'h7FFF, 15'd0, 15'd16, 15'd0);
        repeat (3) send_fields(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00);
        send_fields(1'b1, 8'h20, 8'h80, 8'h00, 8'h00);
        drain_reports();

        apply_settings(15'h7FFF, 15'h7FFF, 15'd31, 15'd16);
        repeat (4) send_fields(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h03);
        drain_reports();

        // Scale writes with upper bits set: only the low five bits count
        apply_settings(15'd100, 15'd50, 15'h7FE1, 15'h7FE0);
        send_fields(1'b0, 8'h00, 8'h05, 8'h05, 8'h00);  // no clamp yet
        send_fields(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);  // clamp applies now
        drain_reports();

        apply_settings(15'd0, 15'h7FFF, 15'd1, 15'd1);
        send_fields(1'b1, 8'h05, 8'h7F, 8'h01, 8'h08);
        drain_reports();
    endtask

    // Random packets under several random register settings
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        mouse_packet_t pkt;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int blk = 0; blk < 4; blk++) begin
            apply_settings(pick_limit(), pick_limit(), pick_scale(), pick_scale());
            for (int i = 0; i < n_items / 4; i++) begin
                pkt.complete = ($urandom_range(99) < 88);
                pkt.flags    = ps2mpt_pkg::byte_t'($urandom);
                pkt.dx       = ps2mpt_pkg::byte_t'($urandom);
                pkt.dy       = ps2mpt_pkg::byte_t'($urandom);
                pkt.wheel    = ps2mpt_pkg::byte_t'($urandom);
                if ($urandom_range(3) == 0) begin
                    pkt.wheel[3:0] = 4'd0;
                end
                send_packet(pkt);
            end
            drain_reports();
        end
    endtask

    // Main sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_packets();
        test_register_extremes();
        test_random_traffic(32, 79, 476);
        test_random_traffic(79, 32, 476);
        test_random_traffic(0, 0, 476);

        repeat (8) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("ps2_mouse_position_tracker_tb: clean");
        end else begin
            $display("ps2_mouse_position_tracker_tb: errors");
        end
        $finish;
    end

endmodule

// ----- ps2_mouse_position_tracker.f -----
rtl/core/ps2mpt_pkg.sv
rtl/core/ps2_mouse_position_tracker.sv
dv/ps2_mouse_position_tracker_tb.sv
